// File: hw/rtl/matrix_multiply_engine_defines.svh
// Assertion macros for the matrix multiply engine RTL.
// Included by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define MME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MME_ASSERT_IMP(lbl, ante, cons, msg)
`define MME_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
// No dependencies; compile first.
package mme_pkg;

  localparam int unsigned MAX_DIM_DEF    = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 16;

  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_IN_W = 4;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned PROD_W   = 36;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CMP_W    = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_READ    = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic start;
    logic issue;
    logic load_out;
  } mme_cmd_t;

  typedef struct packed {
    logic busy;
  } mme_dp_status_t;

endpackage

// File: hw/rtl/mme_if.sv
// Item channel interfaces of the matrix multiply engine.
// Depends on mme_pkg.
interface mme_in_if import mme_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic [IDX_IN_W-1:0]        row;
  logic [IDX_IN_W-1:0]        col;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface mme_out_if import mme_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [PROD_W-1:0]  product;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, product, status, input ready);
  modport sink   (input valid, product, status, output ready);
endinterface

// File: hw/rtl/mme_datapath.sv
// Datapath: A and B element stores, read registers, multiplier, accumulator and output register.
// Depends on mme_pkg; driven by mme_controller.
module mme_datapath import mme_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mme_cmd_t                   cmd_i,
  input  logic [CFG_W-1:0]           k_i,
  input  logic [IDX_IN_W-1:0]        row_i,
  input  logic [IDX_IN_W-1:0]        col_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output mme_dp_status_t             status_o,
  output logic signed [PROD_W-1:0]   product_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned MW    = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];

  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr_a;
  logic [AW-1:0]                rd_addr_b;
  logic signed [ELEM_WIDTH-1:0] wdata;

  logic [IDX_IN_W-1:0]          row_q;
  logic [IDX_IN_W-1:0]          col_q;
  logic signed [ELEM_WIDTH-1:0] a_q;
  logic signed [ELEM_WIDTH-1:0] b_q;
  logic signed [MW-1:0]         mul_q;
  logic signed [PROD_W-1:0]     acc_q;
  logic signed [PROD_W-1:0]     product_q;
  logic                         rd_vld_q;
  logic                         mul_vld_q;

  assign wr_addr   = AW'(row_i) * AW'(MAX_DIM) + AW'(col_i);
  assign rd_addr_a = AW'(row_q) * AW'(MAX_DIM) + AW'(k_i);
  assign rd_addr_b = AW'(k_i) * AW'(MAX_DIM) + AW'(col_q);
  assign wdata     = ELEM_WIDTH'(value_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      mem_a[wr_addr] <= wdata;
    end
    if (cmd_i.wr_b) begin
      mem_b[wr_addr] <= wdata;
    end
    if (cmd_i.issue) begin
      a_q <= mem_a[rd_addr_a];
      b_q <= mem_b[rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (rd_vld_q) begin
      mul_q <= a_q * b_q;
    end
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (mul_vld_q) begin
      acc_q <= acc_q + PROD_W'(mul_q);
    end
    if (cmd_i.load_out) begin
      product_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.issue;
      mul_vld_q <= rd_vld_q;
    end
  end

  assign status_o.busy = rd_vld_q | mul_vld_q;
  assign product_o     = product_q;

endmodule

// File: hw/rtl/mme_controller.sv
// Controller: configuration registers, command decode, term sequencing, output handshake.
// Depends on mme_pkg and matrix_multiply_engine_defines.svh.
`include "matrix_multiply_engine_defines.svh"

module mme_controller import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  input  logic [CMD_W-1:0]      in_command_i,
  input  logic [IDX_IN_W-1:0]   in_row_i,
  input  logic [IDX_IN_W-1:0]   in_col_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [STATUS_W-1:0]   out_status_o,
  output mme_cmd_t              cmd_o,
  output logic [CFG_W-1:0]      k_o,
  input  mme_dp_status_t        dp_status_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] rows_a_q;
  logic [CFG_W-1:0] cols_a_q;
  logic [CFG_W-1:0] rows_b_q;
  logic [CFG_W-1:0] cols_b_q;
  logic [CFG_W-1:0] k_q;
  logic [CFG_W-1:0] n_q;
  status_e          status_q;
  status_e          out_status_q;
  logic             out_valid_q;

  logic             accept;
  logic             wr_in_range;
  logic             is_write_a;
  logic             is_write_b;
  logic             is_read;
  logic [CFG_W-1:0] n_d;
  status_e          rd_status;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    return (CMP_W'(d) > CMP_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : d;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    is_write_a = 1'b0;
    is_write_b = 1'b0;
    is_read    = 1'b0;
    case (cmd_e'(in_command_i))
      CMD_WRITE_A: is_write_a = 1'b1;
      CMD_WRITE_B: is_write_b = 1'b1;
      CMD_READ:    is_read    = 1'b1;
      default:     is_read    = 1'b0;
    endcase
  end

  assign wr_in_range = (CMP_W'(in_row_i) < CMP_W'(MAX_DIM)) &&
                       (CMP_W'(in_col_i) < CMP_W'(MAX_DIM));
  assign n_d = clamp_dim(cols_a_q);

  always_comb begin
    if (cols_a_q != rows_b_q) begin
      rd_status = ST_MISMATCH;
    end else if ((CFG_W'(in_row_i) >= clamp_dim(rows_a_q)) ||
                 (CFG_W'(in_col_i) >= clamp_dim(cols_b_q))) begin
      rd_status = ST_RANGE;
    end else begin
      rd_status = ST_OK;
    end
  end

  always_comb begin
    cmd_o.wr_a     = accept && is_write_a && wr_in_range;
    cmd_o.wr_b     = accept && is_write_b && wr_in_range;
    cmd_o.start    = accept && is_read;
    cmd_o.issue    = (state_q == S_RUN);
    cmd_o.load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  end

  assign k_o          = k_q;
  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rows_a_q     <= CFG_W'(1);
      cols_a_q     <= CFG_W'(1);
      rows_b_q     <= CFG_W'(1);
      cols_b_q     <= CFG_W'(1);
      k_q          <= '0;
      n_q          <= '0;
      status_q     <= ST_OK;
      out_status_q <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ROWS_A: rows_a_q <= cfg_data_i;
          REG_COLS_A: cols_a_q <= cfg_data_i;
          REG_ROWS_B: rows_b_q <= cfg_data_i;
          REG_COLS_B: cols_b_q <= cfg_data_i;
          default:    rows_a_q <= rows_a_q;
        endcase
      end

      if (cmd_o.load_out) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (cmd_o.start) begin
            status_q <= rd_status;
            n_q      <= n_d;
            k_q      <= '0;
            if ((rd_status == ST_OK) && (n_d != '0)) begin
              state_q <= S_RUN;
            end else begin
              state_q <= S_DRAIN;
            end
          end
        end
        S_RUN: begin
          k_q <= k_q + CFG_W'(1);
          if (k_q == n_q - CFG_W'(1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!dp_status_i.busy) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (cmd_o.load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `MME_ASSERT_IMP(a_run_below_count, state_q == S_RUN, k_q < n_q, "term index past count")
  `MME_ASSERT_NXT(a_mismatch_first, cmd_o.start && (cols_a_q != rows_b_q), status_q == ST_MISMATCH, "size mismatch not flagged")
  `MME_ASSERT_NXT(a_hold_full_output, (state_q == S_FINISH) && out_valid_q && !out_ready_i, state_q == S_FINISH, "result dropped over a pending item")
  `MME_ASSERT_NXT(a_write_stays_idle, accept && !is_read, state_q == S_IDLE, "write left idle")

endmodule

// File: hw/rtl/matrix_multiply_engine.sv
// Matrix multiply engine: holds A and B (up to MAX_DIM square) and returns one entry of A*B per
// read item. A read item that passes its checks runs n terms, n being cols_a capped at MAX_DIM:
// one multiply-accumulate term per cycle through the single read port of each store and the one
// multiplier; then the read, multiply and accumulate registers drain and the sum loads the output
// register. A read rejected for size mismatch or an index out of range skips the terms. No item
// is taken until a read is through. A finished result waits in the output register while write
// items go on. Store contents are undefined after reset; read only entries that were written.
module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  mme_in_if.sink               in_ch,
  mme_out_if.source            out_ch
);

  mme_cmd_t         cmd;
  mme_dp_status_t   dp_status;
  logic [CFG_W-1:0] k_idx;

  mme_controller #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_ch.valid),
    .in_command_i (in_ch.command),
    .in_row_i     (in_ch.row),
    .in_col_i     (in_ch.col),
    .in_ready_o   (in_ch.ready),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_status_o (out_ch.status),
    .cmd_o        (cmd),
    .k_o          (k_idx),
    .dp_status_i  (dp_status)
  );

  mme_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .k_i       (k_idx),
    .row_i     (in_ch.row),
    .col_i     (in_ch.col),
    .value_i   (in_ch.value),
    .status_o  (dp_status),
    .product_o (out_ch.product)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the matrix multiply engine: queues element writes, product reads and
// unused commands over several matrix shapes, predicts every product entry and checks the results.
// Depends on mme_pkg, mme_if and the engine RTL.
module testbench;
  import mme_pkg::*;

  localparam int unsigned DIM = MAX_DIM_DEF;
  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned HOLD_SPACING = 120;
  localparam int unsigned STALL_LIMIT = 5000;

  typedef enum int unsigned {
    RX_STEADY,
    RX_RANDOM,
    RX_SPARSE
  } rx_mode_e;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [IDX_IN_W-1:0]       row;
    logic [IDX_IN_W-1:0]       col;
    logic signed [VALUE_W-1:0] value;
    bit                        wait_drain;
  } cmd_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    status_e                  status;
  } entry_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  mme_in_if  in_ch ();
  mme_out_if out_ch ();

  matrix_multiply_engine u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  logic [CFG_W-1:0] dim_rows_a = 5'd1;
  logic [CFG_W-1:0] dim_cols_a = 5'd1;
  logic [CFG_W-1:0] dim_rows_b = 5'd1;
  logic [CFG_W-1:0] dim_cols_b = 5'd1;

  logic signed [VALUE_W-1:0] store_a [DIM][DIM];
  logic signed [VALUE_W-1:0] store_b [DIM][DIM];
  bit                        planned_a [DIM][DIM];
  bit                        planned_b [DIM][DIM];

  cmd_item_t     pending_items[$];
  entry_result_t results_due[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_planned = 0;
  bit          in_taken = 1'b0;
  bit          out_taken;

  bit          offering = 1'b0;
  cmd_item_t   cur_item;
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  int unsigned hold_left = 0;
  int unsigned next_hold_at = 40;
  int unsigned pattern_left = 0;
  rx_mode_e    rx_mode = RX_STEADY;
  logic        rx_ready;

  always #5 clk_i = ~clk_i;

  function automatic int unsigned capped(logic [CFG_W-1:0] d);
    return (d > DIM) ? DIM : int'(d);
  endfunction

  function automatic entry_result_t product_entry(logic [IDX_IN_W-1:0] r,
                                                  logic [IDX_IN_W-1:0] c);
    entry_result_t     res;
    logic [PROD_W-1:0] acc;
    longint            term;
    acc = '0;
    res.status = ST_OK;
    if (dim_cols_a != dim_rows_b) begin
      res.status = ST_MISMATCH;
    end else if (r >= capped(dim_rows_a) || c >= capped(dim_cols_b)) begin
      res.status = ST_RANGE;
    end else begin
      for (int k = 0; k < capped(dim_cols_a); k++) begin
        term = longint'(store_a[r][k]) * longint'(store_b[k][c]);
        acc += term[PROD_W-1:0];
      end
    end
    res.product = acc;
    return res;
  endfunction

  function automatic logic signed [VALUE_W-1:0] any_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_index(int unsigned lim);
    if (lim == 0 || $urandom_range(0, 4) == 0) return $urandom_range(0, DIM - 1);
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic void queue_item(logic [CMD_W-1:0] cmd, int unsigned r, int unsigned c,
                                     logic signed [VALUE_W-1:0] v, bit drain);
    cmd_item_t it;
    it.command = cmd;
    it.row = IDX_IN_W'(r);
    it.col = IDX_IN_W'(c);
    it.value = v;
    it.wait_drain = drain;
    pending_items.push_back(it);
    if (cmd == CMD_WRITE_A) planned_a[r][c] = 1'b1;
    if (cmd == CMD_WRITE_B) planned_b[r][c] = 1'b1;
    if (cmd != CMD_IGNORED) items_planned++;
  endfunction

  // Write every element the dot product touches before the read goes out.
  function automatic void queue_read(int unsigned r, int unsigned c, bit drain);
    if (dim_cols_a == dim_rows_b && r < capped(dim_rows_a) && c < capped(dim_cols_b)) begin
      for (int k = 0; k < capped(dim_cols_a); k++) begin
        if (!planned_a[r][k]) queue_item(CMD_WRITE_A, r, k, any_value(), 1'b0);
        if (!planned_b[k][c]) queue_item(CMD_WRITE_B, k, c, any_value(), 1'b0);
      end
    end
    queue_item(CMD_READ, r, c, any_value(), drain);
  endfunction

  function automatic void random_item();
    int unsigned pick;
    int unsigned r;
    int unsigned c;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      queue_item(CMD_IGNORED, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                 any_value(), 1'b0);
    end else if (pick < 35) begin
      r = pick_index(capped(dim_rows_a));
      c = pick_index(capped(dim_cols_a));
      queue_item(CMD_WRITE_A, r, c, any_value(), 1'b0);
    end else if (pick < 65) begin
      r = pick_index(capped(dim_rows_b));
      c = pick_index(capped(dim_cols_b));
      queue_item(CMD_WRITE_B, r, c, any_value(), 1'b0);
    end else begin
      r = pick_index(capped(dim_rows_a));
      c = pick_index(capped(dim_cols_b));
      queue_read(r, c, $urandom_range(0, 49) == 0);
    end
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ROWS_A: dim_rows_a = val;
      REG_COLS_A: dim_cols_a = val;
      REG_ROWS_B: dim_rows_b = val;
      REG_COLS_B: dim_cols_b = val;
      default: ;
    endcase
  endtask

  task automatic set_dims(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                          logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
    wait_idle();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_COLS_A, ca);
    write_reg(REG_ROWS_B, rb);
    write_reg(REG_COLS_B, cb);
  endtask

  task automatic random_phase(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
                              logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb, int unsigned n);
    int unsigned start;
    set_dims(ra, ca, rb, cb);
    start = items_planned;
    while (items_planned - start < n) random_item();
  endtask

  // Predict on accepted items, check accepted results, watch for a hang.
  always @(posedge clk_i) begin
    entry_result_t want;
    in_taken = in_ch.valid && in_ch.ready;
    out_taken = out_ch.valid && out_ch.ready;
    if (out_taken) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("unexpected result: product %0d status %0d", out_ch.product, out_ch.status);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.product !== want.product) begin
          $error("product: expected %0d, got %0d", want.product, out_ch.product);
          mismatches++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          mismatches++;
        end
      end
    end
    if (in_taken) begin
      case (in_ch.command)
        CMD_WRITE_A: store_a[in_ch.row][in_ch.col] = in_ch.value;
        CMD_WRITE_B: store_b[in_ch.row][in_ch.col] = in_ch.value;
        CMD_READ: results_due.push_back(product_entry(in_ch.row, in_ch.col));
        default: ;
      endcase
    end
    if (in_taken || out_taken) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sender: hold each item until taken, then advance; bursts with random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        void'(pending_items.pop_front());
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].wait_drain && results_due.size() != 0)) begin
          offering = 1'b1;
          cur_item = pending_items[0];
        end
      end
      in_ch.valid <= offering;
      in_ch.command <= cur_item.command;
      in_ch.row <= cur_item.row;
      in_ch.col <= cur_item.col;
      in_ch.value <= cur_item.value;
    end
  end

  // Receiver: stall pattern of its own, with long holds now and then.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += HOLD_SPACING;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_ready = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          pattern_left = $urandom_range(8, 60);
        end
        pattern_left--;
        case (rx_mode)
          RX_STEADY: rx_ready = 1'b1;
          RX_RANDOM: rx_ready = ($urandom_range(0, 1) == 1);
          default: rx_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ch.ready <= rx_ready;
    end
  end

  initial begin
    logic [CFG_W-1:0] ca;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_ROWS_A;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_WRITE_A;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cur_item = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_item(CMD_WRITE_A, 0, 0, 16'sh8000, 1'b0);
    queue_item(CMD_WRITE_B, 0, 0, 16'sh8000, 1'b0);
    queue_read(0, 0, 1'b1);
    queue_read(0, 1, 1'b0);
    queue_read(1, 0, 1'b0);
    queue_item(CMD_IGNORED, 15, 15, 16'sh7fff, 1'b0);
    queue_item(CMD_WRITE_A, 15, 15, 16'sh7fff, 1'b0);
    queue_item(CMD_WRITE_B, 15, 15, -16'sd1, 1'b0);
    queue_read(15, 15, 1'b0);

    set_dims(5'd2, 5'd2, 5'd2, 5'd2);
    queue_item(CMD_WRITE_A, 0, 1, 16'sh7fff, 1'b0);
    queue_item(CMD_WRITE_B, 1, 0, 16'sh7fff, 1'b0);
    queue_read(0, 0, 1'b0);
    queue_read(2, 1, 1'b0);

    set_dims(5'd3, 5'd4, 5'd5, 5'd3);
    queue_read(0, 0, 1'b0);

    set_dims(5'd4, 5'd0, 5'd0, 5'd4);
    queue_read(3, 3, 1'b0);
    queue_read(4, 0, 1'b0);

    set_dims(5'd0, 5'd31, 5'd31, 5'd0);
    queue_read(0, 0, 1'b0);

    random_phase(5'd2, 5'd3, 5'd3, 5'd2, 60);
    random_phase(5'd16, 5'd16, 5'd16, 5'd16, 170);
    random_phase(5'd31, 5'd31, 5'd31, 5'd31, 60);
    random_phase(5'd1, 5'd16, 5'd16, 5'd1, 60);
    random_phase(5'd16, 5'd1, 5'd1, 5'd16, 60);
    random_phase(5'd5, 5'd0, 5'd0, 5'd7, 40);
    random_phase(5'd7, 5'd6, 5'd5, 5'd4, 30);
    random_phase(5'd0, 5'd3, 5'd3, 5'd0, 30);
    repeat (3) begin
      ca = CFG_W'($urandom_range(0, 31));
      random_phase(CFG_W'($urandom_range(1, 20)), ca,
                   ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31)) : ca,
                   CFG_W'($urandom_range(1, 20)), 60);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
